### hdl/pfca_pkg.sv
// shared types and constants for the paged free chunk allocator
package pfca_pkg;

   localparam logic       ACTION_ALLOC      = 1'b0;
   localparam logic       ACTION_FREE       = 1'b1;

   localparam logic [1:0] SOURCE_REUSED     = 2'd0;
   localparam logic [1:0] SOURCE_RECLAIMED  = 2'd1;
   localparam logic [1:0] SOURCE_FRESH      = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_FRESH   = 2'd1;
   localparam logic [1:0] STATUS_NO_LEVEL   = 2'd2;

   localparam logic [15:0] FIRST_FRESH_RESET = 16'd2;

   typedef struct packed {
      logic        action;
      logic [15:0] chunk_index;
   } req_word_type;

   typedef struct packed {
      logic [15:0] chunk_index_out;
      logic [1:0]  source;
      logic        spilled;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic respond;
   } ctrl_cmd_type;

endpackage

### hdl/pfca_ram.sv
// generic single write port ram with registered read
module pfca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

### hdl/pfca_ctrl.sv
// sequencing state machine: capture, execute, respond
module pfca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output pfca_pkg::ctrl_cmd_type cmd
);
   import pfca_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_EXECUTE = 3'b010,
      ST_RESPOND = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_RESPOND: begin
            state_in = start ? ST_EXECUTE : ST_IDLE;
         end
         ST_EXECUTE: begin
            state_in = ST_RESPOND;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff == ST_EXECUTE);
   assign cmd.capture = start && !busy;
   assign cmd.execute = (state_ff == ST_EXECUTE);
   assign cmd.respond = (state_ff == ST_RESPOND);

   a_capture_then_execute: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("captured word not executed");

   a_execute_then_respond: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> cmd.respond)
      else $error("executed word not answered");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");

endmodule

### hdl/pfca_dp.sv
// allocator datapath: page stack state, entry and page memories, result
module pfca_dp #(
   parameter int ENTRIES    = 64,
   parameter int MAX_LEVELS = 16,
   parameter int CHUNK_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfca_pkg::ctrl_cmd_type cmd,
   input  pfca_pkg::req_word_type req_word,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data,
   output pfca_pkg::rsp_word_type rsp_word
);
   import pfca_pkg::*;

   localparam int DEPTH   = ENTRIES * MAX_LEVELS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int FILL_W  = $clog2(ENTRIES + 1);
   localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int ENTRY_W = (CHUNK_BITS < 16) ? CHUNK_BITS : 16;
   localparam int NF_W    = ((CHUNK_BITS > 16) ? CHUNK_BITS : 16) + 1;

   typedef enum logic [1:0] {
      SEL_REG   = 2'd0,
      SEL_ENTRY = 2'd1,
      SEL_PAGE  = 2'd2
   } sel_type;

   logic               action_ff;
   logic [ENTRY_W-1:0] chunk_ff;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [NF_W-1:0]    next_fresh_ff, next_fresh_in;
   logic [15:0]        res_ff, res_in;
   sel_type            sel_ff, sel_in;
   logic [1:0]         source_ff, source_in;
   logic               spilled_ff, spilled_in;
   logic [1:0]         status_ff, status_in;

   logic               fresh_gone;
   logic               fill_full;
   logic               level_top;
   logic               entry_we;
   logic               page_we;
   logic [LVL_W-1:0]   slot_level;
   logic [FILL_W-1:0]  slot_pos;
   logic [ADDR_W-1:0]  entry_addr;
   logic [ENTRY_W-1:0] entry_rdata;
   logic [LVL_W-1:0]   page_waddr;
   logic [15:0]        page_rdata;

   assign fresh_gone = |next_fresh_ff[NF_W-1:CHUNK_BITS];
   assign fill_full  = (fill_ff == FILL_W'(ENTRIES));
   assign level_top  = (level_ff == LVL_W'(MAX_LEVELS - 1));
   assign page_waddr = level_ff + LVL_W'(1);

   always_comb begin
      level_in      = level_ff;
      fill_in       = fill_ff;
      next_fresh_in = next_fresh_ff;
      res_in        = '0;
      sel_in        = SEL_REG;
      source_in     = SOURCE_REUSED;
      spilled_in    = 1'b0;
      status_in     = STATUS_OK;
      entry_we      = 1'b0;
      page_we       = 1'b0;
      slot_level    = level_ff;
      slot_pos      = fill_ff;
      if (action_ff == ACTION_ALLOC) begin
         if (fill_ff != '0) begin
            slot_pos  = fill_ff - FILL_W'(1);
            fill_in   = fill_ff - FILL_W'(1);
            sel_in    = SEL_ENTRY;
            source_in = SOURCE_REUSED;
         end else if (level_ff != '0) begin
            level_in  = level_ff - LVL_W'(1);
            fill_in   = FILL_W'(ENTRIES);
            sel_in    = SEL_PAGE;
            source_in = SOURCE_RECLAIMED;
         end else if (fresh_gone) begin
            status_in = STATUS_NO_FRESH;
         end else begin
            res_in        = next_fresh_ff[15:0];
            next_fresh_in = next_fresh_ff + NF_W'(1);
            source_in     = SOURCE_FRESH;
         end
      end else begin
         if (!fill_full) begin
            entry_we = 1'b1;
            fill_in  = fill_ff + FILL_W'(1);
         end else if (level_top) begin
            status_in = STATUS_NO_LEVEL;
         end else if (fresh_gone) begin
            status_in = STATUS_NO_FRESH;
         end else begin
            entry_we      = 1'b1;
            page_we       = 1'b1;
            slot_level    = page_waddr;
            slot_pos      = '0;
            level_in      = page_waddr;
            fill_in       = FILL_W'(1);
            next_fresh_in = next_fresh_ff + NF_W'(1);
            res_in        = next_fresh_ff[15:0];
            spilled_in    = 1'b1;
         end
      end
   end

   assign entry_addr = ADDR_W'(slot_level) * ADDR_W'(ENTRIES) + ADDR_W'(slot_pos);

   pfca_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock         (clock),
      .write_enable  (cmd.execute && entry_we),
      .write_address (entry_addr),
      .write_data    (chunk_ff),
      .read_address  (entry_addr),
      .read_data     (entry_rdata)
   );

   pfca_ram #(
      .WIDTH (16),
      .DEPTH (MAX_LEVELS)
   ) u_page_ram (
      .clock         (clock),
      .write_enable  (cmd.execute && page_we),
      .write_address (page_waddr),
      .write_data    (next_fresh_ff[15:0]),
      .read_address  (level_ff),
      .read_data     (page_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_word.action;
         chunk_ff  <= req_word.chunk_index[ENTRY_W-1:0];
      end
      if (cmd.execute) begin
         res_ff     <= res_in;
         sel_ff     <= sel_in;
         source_ff  <= source_in;
         spilled_ff <= spilled_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         fill_ff       <= '0;
         next_fresh_ff <= NF_W'(FIRST_FRESH_RESET);
      end else if (csr_write_enable) begin
         next_fresh_ff <= NF_W'(csr_write_data);
      end else if (cmd.execute) begin
         level_ff      <= level_in;
         fill_ff       <= fill_in;
         next_fresh_ff <= next_fresh_in;
      end
   end

   always_comb begin
      rsp_word.source  = source_ff;
      rsp_word.spilled = spilled_ff;
      rsp_word.status  = status_ff;
      case (sel_ff)
         SEL_ENTRY: rsp_word.chunk_index_out = 16'(entry_rdata);
         SEL_PAGE:  rsp_word.chunk_index_out = page_rdata;
         default:   rsp_word.chunk_index_out = res_ff;
      endcase
   end

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ENTRIES))
      else $error("page fill beyond capacity");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && (status_ff != STATUS_OK) |->
         (source_ff == SOURCE_REUSED) && !spilled_ff && (sel_ff == SEL_REG))
      else $error("error word carries payload");

   a_spill_sets_first: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && spilled_in && !csr_write_enable |=> (fill_ff == FILL_W'(1)))
      else $error("spill did not open page with one entry");

endmodule

### hdl/paged_free_chunk_allocator.sv
// paged free chunk allocator top level
// a word captured at an edge passes the execute state, then the respond state, where it is answered
// a new word can be captured in the respond state of the previous one; busy is high for the
// execute cycle only
// the answer stands for one cycle with rsp_valid and cannot be held off
// synchronous reset: empty root page at level 0, next fresh chunk 2, memories left as they are
module paged_free_chunk_allocator #(
   parameter int ENTRIES    = 64,
   parameter int MAX_LEVELS = 16,
   parameter int CHUNK_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pfca_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output pfca_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data
);
   import pfca_pkg::*;

   ctrl_cmd_type cmd;

   pfca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   pfca_dp #(
      .ENTRIES    (ENTRIES),
      .MAX_LEVELS (MAX_LEVELS),
      .CHUNK_BITS (CHUNK_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_word         (rsp_word)
   );

   assign rsp_valid = cmd.respond;

endmodule

### tb/tb_top.sv
// self-checking testbench for the paged free chunk allocator: directed and random words
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfca_pkg::*;

   localparam int          PAGE_ENTRIES   = 64;
   localparam int          PAGE_LEVELS    = 16;
   localparam int          CHUNK_WIDTH    = 16;
   localparam logic [16:0] FRESH_END      = 17'h10000;
   localparam int          WATCHDOG_LIMIT = 1000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_write_enable;
   logic [15:0]  csr_write_data;

   logic [15:0]  held_chunks [0:PAGE_ENTRIES*PAGE_LEVELS-1];
   logic [15:0]  page_home [0:PAGE_LEVELS-1];
   int           cur_level;
   int           held_count;
   logic [16:0]  fresh_cursor;

   rsp_word_type expected_answers [$];
   int           mismatch_count;
   int           idle_max;
   int           quiet_cycles;

   paged_free_chunk_allocator #(
      .ENTRIES    (PAGE_ENTRIES),
      .MAX_LEVELS (PAGE_LEVELS),
      .CHUNK_BITS (CHUNK_WIDTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_word_type chunk_answer(input req_word_type w);
      rsp_word_type r;
      r = '0;
      if (w.action == ACTION_ALLOC) begin
         if (held_count > 0) begin
            held_count--;
            r.chunk_index_out = held_chunks[cur_level*PAGE_ENTRIES + held_count];
            r.source = SOURCE_REUSED;
         end else if (cur_level > 0) begin
            r.chunk_index_out = page_home[cur_level];
            page_home[cur_level] = '0;
            cur_level--;
            held_count = PAGE_ENTRIES;
            r.source = SOURCE_RECLAIMED;
         end else if (fresh_cursor >= FRESH_END) begin
            r.status = STATUS_NO_FRESH;
         end else begin
            r.chunk_index_out = fresh_cursor[15:0];
            fresh_cursor++;
            r.source = SOURCE_FRESH;
         end
      end else begin
         if (held_count < PAGE_ENTRIES) begin
            held_chunks[cur_level*PAGE_ENTRIES + held_count] = w.chunk_index;
            held_count++;
         end else if (cur_level + 1 >= PAGE_LEVELS) begin
            r.status = STATUS_NO_LEVEL;
         end else if (fresh_cursor >= FRESH_END) begin
            r.status = STATUS_NO_FRESH;
         end else begin
            cur_level++;
            page_home[cur_level] = fresh_cursor[15:0];
            held_chunks[cur_level*PAGE_ENTRIES] = w.chunk_index;
            held_count = 1;
            r.chunk_index_out = fresh_cursor[15:0];
            r.spilled = 1'b1;
            fresh_cursor++;
         end
      end
      return r;
   endfunction

   task automatic send_word(input logic act, input logic [15:0] idx);
      int           gap;
      req_word_type w;
      rsp_word_type answer;
      gap = $urandom_range(0, idle_max);
      w.action = act;
      w.chunk_index = idx;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!(start && !busy));
      answer = chunk_answer(w);
      expected_answers = {expected_answers, answer};
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_first_fresh(input logic [15:0] value);
      drain_answers();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fresh_cursor = {1'b0, value};
   endtask

   task automatic test_fresh_and_reuse();
      idle_max = 17;
      send_word(ACTION_ALLOC, 16'h0000);
      send_word(ACTION_ALLOC, 16'hFFFF);
      send_word(ACTION_FREE, 16'hFFFF);
      send_word(ACTION_FREE, 16'h0000);
      send_word(ACTION_FREE, 16'h5A5A);
      send_word(ACTION_ALLOC, 16'hA5A5);
      send_word(ACTION_ALLOC, 16'h0000);
      send_word(ACTION_ALLOC, 16'hFFFF);
      send_word(ACTION_ALLOC, 16'h1234);
   endtask

   task automatic test_fresh_exhaustion();
      write_first_fresh(16'hFFFF);
      send_word(ACTION_ALLOC, 16'h0000);
      send_word(ACTION_ALLOC, 16'h0000);
   endtask

   task automatic test_spill_and_reclaim();
      write_first_fresh(16'h0000);
      while (held_count < PAGE_ENTRIES)
         send_word(ACTION_FREE, 16'($urandom_range(0, 65535)));
      send_word(ACTION_FREE, 16'h8001);
      send_word(ACTION_ALLOC, 16'h0000);
      send_word(ACTION_ALLOC, 16'h0000);
      send_word(ACTION_ALLOC, 16'h0000);
   endtask

   task automatic test_level_exhaustion();
      write_first_fresh(16'h8000);
      while (!(cur_level == PAGE_LEVELS - 3 && held_count == PAGE_ENTRIES))
         send_word(ACTION_FREE, 16'($urandom_range(0, 65535)));
      write_first_fresh(16'hFFFF);
      while (!(cur_level == PAGE_LEVELS - 2 && held_count == PAGE_ENTRIES))
         send_word(ACTION_FREE, 16'($urandom_range(0, 65535)));
      send_word(ACTION_FREE, 16'h3C3C);
      write_first_fresh(16'hFFFF);
      while (!(cur_level == PAGE_LEVELS - 1 && held_count == PAGE_ENTRIES))
         send_word(ACTION_FREE, 16'($urandom_range(0, 65535)));
      send_word(ACTION_FREE, 16'h7777);
      send_word(ACTION_FREE, 16'h0001);
      send_word(ACTION_ALLOC, 16'h0000);
      send_word(ACTION_ALLOC, 16'h0000);
   endtask

   task automatic test_random_traffic();
      int          burst;
      int          free_pct;
      int          sent;
      logic [15:0] base;
      for (int phase = 0; phase < 3; phase++) begin
         case ($urandom_range(0, 2))
            0:       base = 16'($urandom_range(0, 65535));
            1:       base = 16'(65535 - $urandom_range(0, 300));
            default: base = 16'($urandom_range(0, 40));
         endcase
         write_first_fresh(base);
         sent = 0;
         while (sent < 50) begin
            burst = $urandom_range(1, 25);
            free_pct = $urandom_range(0, 1) ? 80 : 25;
            idle_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
            repeat (burst) begin
               if ($urandom_range(0, 99) < free_pct)
                  send_word(ACTION_FREE, 16'($urandom_range(0, 65535)));
               else
                  send_word(ACTION_ALLOC, 16'($urandom_range(0, 65535)));
               sent++;
            end
            // in phase 1 only, hold the sender until every answer is back
            if (phase == 1)
               drain_answers();
         end
      end
      idle_max = 17;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: chunk %h source %0d spilled %0d status %0d",
                        rsp_word.chunk_index_out, rsp_word.source, rsp_word.spilled,
                        rsp_word.status);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_word.chunk_index_out !== want.chunk_index_out ||
                rsp_word.source !== want.source ||
                rsp_word.spilled !== want.spilled ||
                rsp_word.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("word mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                           want.chunk_index_out, want.source, want.spilled, want.status,
                           rsp_word.chunk_index_out, rsp_word.source, rsp_word.spilled,
                           rsp_word.status);
            end
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      mismatch_count = 0;
      idle_max = 17;
      for (int i = 0; i < PAGE_LEVELS; i++)
         page_home[i] = '0;
      page_home[0] = 16'd1;
      cur_level = 0;
      held_count = 0;
      fresh_cursor = {1'b0, FIRST_FRESH_RESET};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fresh_and_reuse();
      test_fresh_exhaustion();
      test_spill_and_reclaim();
      test_random_traffic();
      test_level_exhaustion();

      drain_answers();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
hdl/pfca_pkg.sv
hdl/pfca_ram.sv
hdl/pfca_ctrl.sv
hdl/pfca_dp.sv
hdl/paged_free_chunk_allocator.sv
tb/tb_top.sv
